### sv/awsp_pkg.sv
// Package for the adaptive weighted scenario picker: sizes, codes, FSM states
// and the structs passed between the control block and its arithmetic units.
// No dependencies; every other file but awsp_ram refers to it by scoped names.
package awsp_pkg;

   // table geometry
   localparam int unsigned SYMBOLS      = 13;
   localparam int unsigned WEIGHT_BITS  = 20;
   localparam int unsigned IDX_BITS     = 4;
   localparam int unsigned ENTRIES      = SYMBOLS * SYMBOLS * SYMBOLS;
   localparam int unsigned ADDR_BITS    = $clog2(ENTRIES);
   localparam int unsigned TOTAL_BITS   = WEIGHT_BITS + ADDR_BITS;

   // input and register widths
   localparam int unsigned RAND_BITS    = 32;
   localparam int unsigned DIV_CNT_BITS = $clog2(RAND_BITS);
   localparam int unsigned PCT_BITS     = 7;
   localparam int unsigned FACTOR_BITS  = 8;

   // weight values
   localparam logic [WEIGHT_BITS-1:0] START_WEIGHT = WEIGHT_BITS'(100);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX   = {WEIGHT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0]  RESET_TOTAL  = TOTAL_BITS'(100 * ENTRIES);
   localparam logic [PCT_BITS-1:0]    RESET_PCT    = PCT_BITS'(25);
   localparam logic [FACTOR_BITS-1:0] PERCENT_BASE = FACTOR_BITS'(100);

   // divide by 100 through a reciprocal; the rounding error stays below one
   // unit of the quotient for every product that the scaler can form
   localparam int unsigned PROD_BITS    = WEIGHT_BITS + FACTOR_BITS;
   localparam int unsigned RECIP_SHIFT  = PROD_BITS + 7;
   localparam int unsigned RECIP_BITS   = RECIP_SHIFT - 6;
   localparam int unsigned QP_BITS      = PROD_BITS + RECIP_BITS;
   localparam int unsigned QUO_BITS     = QP_BITS - RECIP_SHIFT;
   localparam logic [63:0] RECIP_FULL   = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];

   // configuration port
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic [0:0]  REG_CHANGE_PERCENT = 1'b0;

   // item codes
   localparam logic OP_SELECT    = 1'b0;
   localparam logic OP_GRADE     = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_GRD_READ,
      ST_GRD_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [TOTAL_BITS-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic                   done;
      logic [WEIGHT_BITS-1:0] weight;
   } scale_rsp_type;

endpackage

### sv/awsp_req_if.sv
// Request channel of the scenario picker: valid/ready plus one item.
// Depends on awsp_pkg for the field widths.
interface awsp_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [awsp_pkg::RAND_BITS-1:0]  random_value;
   logic                            answer_correct;

   modport source (output valid, output operation, output random_value,
                   output answer_correct, input ready);
   modport sink   (input valid, input operation, input random_value,
                   input answer_correct, output ready);
endinterface

### sv/awsp_rsp_if.sv
// Response channel of the scenario picker: valid/ready plus one result.
// Depends on awsp_pkg for the field widths.
interface awsp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [awsp_pkg::IDX_BITS-1:0]     first_index;
   logic [awsp_pkg::IDX_BITS-1:0]     second_index;
   logic [awsp_pkg::IDX_BITS-1:0]     third_index;
   logic [awsp_pkg::WEIGHT_BITS-1:0]  new_weight;
   logic                              status;

   modport source (output valid, output first_index, output second_index,
                   output third_index, output new_weight, output status,
                   input ready);
   modport sink   (input valid, input first_index, input second_index,
                   input third_index, input new_weight, input status,
                   output ready);
endinterface

### sv/awsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module awsp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/awsp_divider.sv
// Restoring remainder unit: random value modulo total weight, one bit a cycle.
// Depends on awsp_pkg for widths and the response struct.
module awsp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [awsp_pkg::RAND_BITS-1:0]    dividend,
   input  logic [awsp_pkg::TOTAL_BITS-1:0]   divisor,
   output awsp_pkg::div_rsp_type             rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [awsp_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [awsp_pkg::RAND_BITS-1:0]      num_ff, num_in;
   logic [awsp_pkg::TOTAL_BITS-1:0]     den_ff, den_in;
   logic [awsp_pkg::TOTAL_BITS-1:0]     rem_ff, rem_in;
   logic [awsp_pkg::TOTAL_BITS:0]       trial;
   logic [awsp_pkg::TOTAL_BITS:0]       diff;
   logic                                last_step;

   // one shift-and-subtract step; the remainder stays below the divisor
   assign trial     = {rem_ff, num_ff[awsp_pkg::RAND_BITS-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign last_step = (cnt_ff == awsp_pkg::DIV_CNT_BITS'(awsp_pkg::RAND_BITS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[awsp_pkg::TOTAL_BITS-1:0];
         end else begin
            rem_in = trial[awsp_pkg::TOTAL_BITS-1:0];
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

endmodule

### sv/awsp_scale.sv
// Weight scaler: weight * factor / 100, truncated and saturated, in three stages
// (product, reciprocal product, saturation). Depends on awsp_pkg.
module awsp_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [awsp_pkg::WEIGHT_BITS-1:0]   weight,
   input  logic [awsp_pkg::FACTOR_BITS-1:0]   factor,
   output awsp_pkg::scale_rsp_type            rsp
);

   logic [2:0]                              vld_ff, vld_in;
   logic [awsp_pkg::PROD_BITS-1:0]          prod_ff, prod_in;
   logic [awsp_pkg::QP_BITS-1:0]            qp_ff, qp_in;
   logic [awsp_pkg::QUO_BITS-1:0]           quo;
   logic [awsp_pkg::WEIGHT_BITS-1:0]        sat_ff, sat_in;

   assign vld_in  = {vld_ff[1:0], start};
   assign prod_in = awsp_pkg::PROD_BITS'(weight) * awsp_pkg::PROD_BITS'(factor);
   assign qp_in   = awsp_pkg::QP_BITS'(prod_ff) * awsp_pkg::QP_BITS'(awsp_pkg::RECIP);
   assign quo     = qp_ff[awsp_pkg::QP_BITS-1:awsp_pkg::RECIP_SHIFT];

   // clamp at the field maximum
   always_comb begin
      if (quo > awsp_pkg::QUO_BITS'(awsp_pkg::WEIGHT_MAX)) begin
         sat_in = awsp_pkg::WEIGHT_MAX;
      end else begin
         sat_in = quo[awsp_pkg::WEIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      qp_ff   <= qp_in;
      sat_ff  <= sat_in;
   end

   assign rsp.done   = vld_ff[2];
   assign rsp.weight = sat_ff;

endmodule

### sv/adaptive_weighted_scenario_picker.sv
// Top level of the adaptive weighted scenario picker: control FSM, table scan,
// totals, CSR and result register. Depends on awsp_pkg, awsp_req_if,
// awsp_rsp_if, awsp_ram, awsp_divider and awsp_scale.
//
//   channel   direction  handshake             payload
//   req_bus   in         valid/ready           operation, random_value, answer_correct
//   rsp_bus   out        valid/ready           first/second/third_index, new_weight, status
//   csr_*     in         APB r/w, pready=1     change_percent at byte address 0
//
// After reset a clearing pass writes every entry of the weight table, one entry
// a cycle; no request is taken meanwhile, CSR writes are.
// Select: accept, remainder unit, scan up to the chosen entry, post.
// Empty select: accept, then post; grade: accept, read, 3-stage scaler, post.
// One item at a time; a stalled rsp_bus holds the next result in ST_DONE, and no
// request is taken until that result is posted.
module adaptive_weighted_scenario_picker (
   input  logic                                  clock,
   input  logic                                  reset,
   awsp_req_if.sink                              req_bus,
   awsp_rsp_if.source                            rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [awsp_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [awsp_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [awsp_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam logic [awsp_pkg::ADDR_BITS-1:0] LAST_ADDR =
      awsp_pkg::ADDR_BITS'(awsp_pkg::ENTRIES - 1);
   localparam logic [awsp_pkg::IDX_BITS-1:0]  SYM_LAST =
      awsp_pkg::IDX_BITS'(awsp_pkg::SYMBOLS - 1);

   awsp_pkg::state_type                  state_ff, state_in;
   logic [awsp_pkg::ADDR_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic [awsp_pkg::TOTAL_BITS-1:0]      total_ff, total_in;
   logic [awsp_pkg::PCT_BITS-1:0]        pct_ff, pct_in;
   logic                                 corr_ff, corr_in;
   logic [awsp_pkg::TOTAL_BITS-1:0]      rem_ff, rem_in;
   logic [awsp_pkg::ADDR_BITS-1:0]       issue_ff, issue_in;
   logic [awsp_pkg::ADDR_BITS-1:0]       data_addr_ff, data_addr_in;
   logic                                 data_vld_ff, data_vld_in;
   logic [awsp_pkg::IDX_BITS-1:0]        ia_ff, ia_in, ib_ff, ib_in, ic_ff, ic_in;
   logic [awsp_pkg::IDX_BITS-1:0]        last_a_ff, last_a_in;
   logic [awsp_pkg::IDX_BITS-1:0]        last_b_ff, last_b_in;
   logic [awsp_pkg::IDX_BITS-1:0]        last_c_ff, last_c_in;
   logic [awsp_pkg::ADDR_BITS-1:0]       last_addr_ff, last_addr_in;
   logic [awsp_pkg::WEIGHT_BITS-1:0]     old_ff, old_in;
   logic [awsp_pkg::IDX_BITS-1:0]        res_a_ff, res_a_in, res_b_ff, res_b_in;
   logic [awsp_pkg::IDX_BITS-1:0]        res_c_ff, res_c_in;
   logic [awsp_pkg::WEIGHT_BITS-1:0]     res_w_ff, res_w_in;
   logic                                 res_st_ff, res_st_in;
   logic                                 out_vld_ff, out_vld_in;
   logic [awsp_pkg::IDX_BITS-1:0]        out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [awsp_pkg::IDX_BITS-1:0]        out_c_ff, out_c_in;
   logic [awsp_pkg::WEIGHT_BITS-1:0]     out_w_ff, out_w_in;
   logic                                 out_st_ff, out_st_in;

   logic                                 req_ready;
   logic                                 req_beat;
   logic                                 slot_free;
   logic                                 hit;
   logic                                 csr_write;
   logic                                 mem_wr_en, mem_rd_en;
   logic [awsp_pkg::ADDR_BITS-1:0]       mem_wr_addr, mem_rd_addr;
   logic [awsp_pkg::WEIGHT_BITS-1:0]     mem_wr_data, mem_rd_data;
   logic                                 div_start, scale_start;
   logic [awsp_pkg::FACTOR_BITS-1:0]     factor;
   awsp_pkg::div_rsp_type                div_rsp;
   awsp_pkg::scale_rsp_type              scale_rsp;

   assign req_beat  = req_bus.valid && req_ready;
   assign slot_free = !out_vld_ff || rsp_bus.ready;
   assign hit       = data_vld_ff && (rem_ff < awsp_pkg::TOTAL_BITS'(mem_rd_data));
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // grade factor: shrink clamps at zero, grow adds the percent
   always_comb begin
      if (corr_ff) begin
         if (pct_ff >= awsp_pkg::PCT_BITS'(awsp_pkg::PERCENT_BASE)) begin
            factor = '0;
         end else begin
            factor = awsp_pkg::PERCENT_BASE - awsp_pkg::FACTOR_BITS'(pct_ff);
         end
      end else begin
         factor = awsp_pkg::PERCENT_BASE + awsp_pkg::FACTOR_BITS'(pct_ff);
      end
   end

   // weight table
   awsp_ram #(
      .WIDTH (awsp_pkg::WEIGHT_BITS),
      .DEPTH (awsp_pkg::ENTRIES)
   ) u_weights (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   awsp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_bus.random_value),
      .divisor  (total_ff),
      .rsp      (div_rsp)
   );

   awsp_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .weight (mem_rd_data),
      .factor (factor),
      .rsp    (scale_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         awsp_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = awsp_pkg::ST_IDLE;
            end
         end
         awsp_pkg::ST_IDLE: begin
            if (req_beat) begin
               if (req_bus.operation == awsp_pkg::OP_GRADE) begin
                  state_in = awsp_pkg::ST_GRD_READ;
               end else if (total_ff == '0) begin
                  state_in = awsp_pkg::ST_DONE;
               end else begin
                  state_in = awsp_pkg::ST_DIV;
               end
            end
         end
         awsp_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = awsp_pkg::ST_SCAN;
            end
         end
         awsp_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = awsp_pkg::ST_DONE;
            end
         end
         awsp_pkg::ST_GRD_READ: begin
            state_in = awsp_pkg::ST_GRD_MUL;
         end
         awsp_pkg::ST_GRD_MUL: begin
            if (scale_rsp.done) begin
               state_in = awsp_pkg::ST_DONE;
            end
         end
         awsp_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = awsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = awsp_pkg::ST_IDLE;
         end
      endcase
   end

   // FSM outputs: handshake, memory ports, unit starts
   always_comb begin
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = last_addr_ff;
      mem_wr_data = scale_rsp.weight;
      mem_rd_en   = 1'b0;
      mem_rd_addr = issue_ff;
      div_start   = 1'b0;
      scale_start = 1'b0;
      case (state_ff)
         awsp_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = awsp_pkg::START_WEIGHT;
         end
         awsp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_beat && req_bus.operation == awsp_pkg::OP_GRADE) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = last_addr_ff;
            end
            if (req_beat && req_bus.operation == awsp_pkg::OP_SELECT && total_ff != '0) begin
               div_start = 1'b1;
            end
         end
         awsp_pkg::ST_SCAN: begin
            mem_rd_en = 1'b1;
         end
         awsp_pkg::ST_GRD_READ: begin
            scale_start = 1'b1;
         end
         awsp_pkg::ST_GRD_MUL: begin
            mem_wr_en = scale_rsp.done;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      total_in     = total_ff;
      pct_in       = pct_ff;
      corr_in      = corr_ff;
      rem_in       = rem_ff;
      issue_in     = issue_ff;
      data_addr_in = data_addr_ff;
      data_vld_in  = (state_ff == awsp_pkg::ST_SCAN) && !hit;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      ic_in        = ic_ff;
      last_a_in    = last_a_ff;
      last_b_in    = last_b_ff;
      last_c_in    = last_c_ff;
      last_addr_in = last_addr_ff;
      old_in       = old_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      res_c_in     = res_c_ff;
      res_w_in     = res_w_ff;
      res_st_in    = res_st_ff;
      out_vld_in   = out_vld_ff && !rsp_bus.ready;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_c_in     = out_c_ff;
      out_w_in     = out_w_ff;
      out_st_in    = out_st_ff;

      if (csr_write && csr_paddr[2] == awsp_pkg::REG_CHANGE_PERCENT) begin
         pct_in = csr_pwdata[awsp_pkg::PCT_BITS-1:0];
      end

      case (state_ff)
         awsp_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         awsp_pkg::ST_IDLE: begin
            if (req_beat) begin
               corr_in   = req_bus.answer_correct;
               // empty table: report without touching the remembered entry
               res_a_in  = '0;
               res_b_in  = '0;
               res_c_in  = '0;
               res_w_in  = '0;
               res_st_in = awsp_pkg::STATUS_EMPTY;
            end
         end
         awsp_pkg::ST_DIV: begin
            rem_in       = div_rsp.rem;
            issue_in     = '0;
            data_addr_in = '0;
            ia_in        = '0;
            ib_in        = '0;
            ic_in        = '0;
         end
         awsp_pkg::ST_SCAN: begin
            if (issue_ff != LAST_ADDR) begin
               issue_in = issue_ff + 1'b1;
            end
            if (hit) begin
               res_a_in     = ia_ff;
               res_b_in     = ib_ff;
               res_c_in     = ic_ff;
               res_w_in     = mem_rd_data;
               res_st_in    = awsp_pkg::STATUS_OK;
               last_a_in    = ia_ff;
               last_b_in    = ib_ff;
               last_c_in    = ic_ff;
               last_addr_in = data_addr_ff;
            end else if (data_vld_ff) begin
               // step past this entry, third index fastest
               rem_in       = rem_ff - awsp_pkg::TOTAL_BITS'(mem_rd_data);
               data_addr_in = data_addr_ff + 1'b1;
               if (ic_ff != SYM_LAST) begin
                  ic_in = ic_ff + 1'b1;
               end else begin
                  ic_in = '0;
                  if (ib_ff != SYM_LAST) begin
                     ib_in = ib_ff + 1'b1;
                  end else begin
                     ib_in = '0;
                     ia_in = ia_ff + 1'b1;
                  end
               end
            end
         end
         awsp_pkg::ST_GRD_READ: begin
            old_in = mem_rd_data;
         end
         awsp_pkg::ST_GRD_MUL: begin
            if (scale_rsp.done) begin
               total_in  = total_ff - awsp_pkg::TOTAL_BITS'(old_ff)
                           + awsp_pkg::TOTAL_BITS'(scale_rsp.weight);
               res_a_in  = last_a_ff;
               res_b_in  = last_b_ff;
               res_c_in  = last_c_ff;
               res_w_in  = scale_rsp.weight;
               res_st_in = awsp_pkg::STATUS_OK;
            end
         end
         awsp_pkg::ST_DONE: begin
            if (slot_free) begin
               out_vld_in = 1'b1;
               out_a_in   = res_a_ff;
               out_b_in   = res_b_ff;
               out_c_in   = res_c_ff;
               out_w_in   = res_w_ff;
               out_st_in  = res_st_ff;
            end
         end
         default: begin
            old_in = old_ff;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awsp_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         total_ff     <= awsp_pkg::RESET_TOTAL;
         pct_ff       <= awsp_pkg::RESET_PCT;
         data_vld_ff  <= 1'b0;
         last_a_ff    <= '0;
         last_b_ff    <= '0;
         last_c_ff    <= '0;
         last_addr_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         total_ff     <= total_in;
         pct_ff       <= pct_in;
         data_vld_ff  <= data_vld_in;
         last_a_ff    <= last_a_in;
         last_b_ff    <= last_b_in;
         last_c_ff    <= last_c_in;
         last_addr_ff <= last_addr_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      corr_ff      <= corr_in;
      rem_ff       <= rem_in;
      issue_ff     <= issue_in;
      data_addr_ff <= data_addr_in;
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      ic_ff        <= ic_in;
      old_ff       <= old_in;
      res_a_ff     <= res_a_in;
      res_b_ff     <= res_b_in;
      res_c_ff     <= res_c_in;
      res_w_ff     <= res_w_in;
      res_st_ff    <= res_st_in;
      out_a_ff     <= out_a_in;
      out_b_ff     <= out_b_in;
      out_c_ff     <= out_c_in;
      out_w_ff     <= out_w_in;
      out_st_ff    <= out_st_in;
   end

   // ports
   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.first_index  = out_a_ff;
   assign rsp_bus.second_index = out_b_ff;
   assign rsp_bus.third_index  = out_c_ff;
   assign rsp_bus.new_weight   = out_w_ff;
   assign rsp_bus.status       = out_st_ff;
   assign csr_pready           = 1'b1;
   assign csr_prdata           = (csr_paddr[2] == awsp_pkg::REG_CHANGE_PERCENT) ?
                                 awsp_pkg::CSR_DATA_BITS'(pct_ff) : '0;

`ifndef NO_ASSERTIONS
   // the scan never reads past the end of the table
   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == awsp_pkg::ST_SCAN && data_vld_ff) |->
      ({1'b0, data_addr_ff} < (awsp_pkg::ADDR_BITS + 1)'(awsp_pkg::ENTRIES)))
      else $error("table scan ran past the last entry");

   // the remainder unit only finishes while the FSM waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == awsp_pkg::ST_DIV))
      else $error("remainder done outside of the divide state");

   // the scaler only finishes while the FSM waits for it
   a_scale_owner: assert property (@(posedge clock) disable iff (reset)
      scale_rsp.done |-> (state_ff == awsp_pkg::ST_GRD_MUL))
      else $error("scaler done outside of the grade state");

   // posting a result always raises the response valid
   a_post_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == awsp_pkg::ST_DONE && slot_free) |=> rsp_bus.valid)
      else $error("posted result did not reach the response register");
`endif

endmodule

### bench/adaptive_weighted_scenario_picker_tb.sv
// Testbench for the adaptive weighted scenario picker: directed and random
// select/grade traffic, APB writes of change_percent, and a weight-table mirror.
// Depends on awsp_pkg, awsp_req_if, awsp_rsp_if and the adaptive_weighted_scenario_picker RTL.
module adaptive_weighted_scenario_picker_tb;

   localparam logic [awsp_pkg::CSR_ADDR_BITS-1:0] PCT_ADDR =
      awsp_pkg::CSR_ADDR_BITS'(4 * awsp_pkg::REG_CHANGE_PERCENT);
   localparam logic [awsp_pkg::CSR_ADDR_BITS-1:0] SPARE_ADDR =
      awsp_pkg::CSR_ADDR_BITS'(4);
   localparam int unsigned MAX_SHOWN = 10;

   typedef struct packed {
      logic [awsp_pkg::IDX_BITS-1:0]    first_index;
      logic [awsp_pkg::IDX_BITS-1:0]    second_index;
      logic [awsp_pkg::IDX_BITS-1:0]    third_index;
      logic [awsp_pkg::WEIGHT_BITS-1:0] new_weight;
      logic                             status;
   } pick_type;

   logic clock = 1'b0;
   logic reset;

   awsp_req_if req_bus ();
   awsp_rsp_if rsp_bus ();

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [awsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [awsp_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [awsp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   // mirror of the block state
   logic [awsp_pkg::WEIGHT_BITS-1:0] weight_mirror [awsp_pkg::ENTRIES];
   longint unsigned                  total_mirror;
   logic [awsp_pkg::IDX_BITS-1:0]    last_a;
   logic [awsp_pkg::IDX_BITS-1:0]    last_b;
   logic [awsp_pkg::IDX_BITS-1:0]    last_c;
   logic [awsp_pkg::PCT_BITS-1:0]    pct_mirror;

   pick_type pending_picks [$];

   int unsigned error_count;
   int unsigned checked_count;
   int unsigned select_count;
   int unsigned grade_count;
   int unsigned setting_count;
   int unsigned rsp_hold;
   bit          quiet_mode;

   adaptive_weighted_scenario_picker dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= MAX_SHOWN) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   // Advance the mirror by one item and return the result it must produce.
   function automatic pick_type predict_pick(logic op, logic [awsp_pkg::RAND_BITS-1:0] rv,
                                             logic correct);
      pick_type        res;
      longint unsigned rem;
      longint unsigned old_w;
      longint unsigned scaled;
      int unsigned     factor;
      int              pos;
      int unsigned     idx;
      res = '0;
      if (op == awsp_pkg::OP_SELECT) begin
         pos = -1;
         if (total_mirror != 0) begin
            rem = longint'(rv) % total_mirror;
            for (int e = 0; e < awsp_pkg::ENTRIES && pos < 0; e++) begin
               if (rem < weight_mirror[e]) begin
                  pos = e;
               end else begin
                  rem -= weight_mirror[e];
               end
            end
         end
         if (pos < 0) begin
            res.status = awsp_pkg::STATUS_EMPTY;
         end else begin
            last_a = awsp_pkg::IDX_BITS'(pos / (awsp_pkg::SYMBOLS * awsp_pkg::SYMBOLS));
            last_b = awsp_pkg::IDX_BITS'((pos / awsp_pkg::SYMBOLS) % awsp_pkg::SYMBOLS);
            last_c = awsp_pkg::IDX_BITS'(pos % awsp_pkg::SYMBOLS);
            res = '{last_a, last_b, last_c, weight_mirror[pos], awsp_pkg::STATUS_OK};
         end
      end else begin
         idx = (last_a * awsp_pkg::SYMBOLS + last_b) * awsp_pkg::SYMBOLS + last_c;
         if (idx >= awsp_pkg::ENTRIES) idx = 0;
         old_w = weight_mirror[idx];
         if (correct) begin
            if (pct_mirror >= awsp_pkg::PERCENT_BASE) begin
               factor = 0;
            end else begin
               factor = int'(awsp_pkg::PERCENT_BASE) - int'(pct_mirror);
            end
         end else begin
            factor = int'(awsp_pkg::PERCENT_BASE) + int'(pct_mirror);
         end
         scaled = (old_w * factor) / awsp_pkg::PERCENT_BASE;
         if (scaled > awsp_pkg::WEIGHT_MAX) scaled = awsp_pkg::WEIGHT_MAX;
         weight_mirror[idx] = awsp_pkg::WEIGHT_BITS'(scaled);
         total_mirror = total_mirror - old_w + scaled;
         res = '{last_a, last_b, last_c, awsp_pkg::WEIGHT_BITS'(scaled), awsp_pkg::STATUS_OK};
      end
      return res;
   endfunction

   // Send one request beat after a random gap and queue its predicted result.
   task automatic send_item(logic op, logic [awsp_pkg::RAND_BITS-1:0] rv, logic correct);
      int unsigned gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= op;
      req_bus.random_value   <= rv;
      req_bus.answer_correct <= correct;
      do @(posedge clock); while (!req_bus.ready);
      pending_picks.push_back(predict_pick(op, rv, correct));
      if (op == awsp_pkg::OP_SELECT) select_count++;
      else grade_count++;
   endtask

   // Lower valid and hold until every queued result has come back.
   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [awsp_pkg::CSR_ADDR_BITS-1:0] addr,
                            logic [awsp_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == PCT_ADDR) begin
         pct_mirror = data[awsp_pkg::PCT_BITS-1:0];
         setting_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Read change_percent back and compare with the mirror.
   task automatic csr_check_percent();
      logic [awsp_pkg::CSR_DATA_BITS-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= PCT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got[awsp_pkg::PCT_BITS-1:0] !== pct_mirror) begin
         note_error($sformatf("change_percent read: expected %0d, got %0d",
                              pct_mirror, got[awsp_pkg::PCT_BITS-1:0]));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Check each result beat against the oldest prediction; draw the next stall.
   always @(posedge clock) begin
      pick_type seen;
      pick_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.first_index, rsp_bus.second_index, rsp_bus.third_index,
                  rsp_bus.new_weight, rsp_bus.status};
         rsp_hold = quiet_mode ? 0 : $urandom_range(0, 5);
         if (pending_picks.size() == 0) begin
            note_error($sformatf("result (%0d,%0d,%0d) w=%0d st=%0d with nothing pending",
                                 seen.first_index, seen.second_index, seen.third_index,
                                 seen.new_weight, seen.status));
         end else begin
            want = pending_picks.pop_front();
            checked_count++;
            if (seen.first_index !== want.first_index ||
                seen.second_index !== want.second_index ||
                seen.third_index !== want.third_index ||
                seen.new_weight !== want.new_weight || seen.status !== want.status) begin
               note_error($sformatf(
                  "expected (%0d,%0d,%0d) w=%0d st=%0d, got (%0d,%0d,%0d) w=%0d st=%0d",
                  want.first_index, want.second_index, want.third_index,
                  want.new_weight, want.status,
                  seen.first_index, seen.second_index, seen.third_index,
                  seen.new_weight, seen.status));
            end
         end
      end
   end

   // Drive result ready: hold low for the drawn stall, then high until the next beat.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Grade with nothing selected yet: entry (0,0,0) grows, then shrinks.
   task automatic test_grade_before_select();
      send_item(awsp_pkg::OP_GRADE, $urandom(), 1'b0);
      send_item(awsp_pkg::OP_GRADE, $urandom(), 1'b1);
   endtask

   // Select with the random value at both ends and once at random; answer_correct set but unused.
   task automatic test_select_extremes();
      send_item(awsp_pkg::OP_SELECT, '0, 1'b0);
      send_item(awsp_pkg::OP_SELECT, '1, 1'b1);
      send_item(awsp_pkg::OP_SELECT, $urandom(), 1'b1);
   endtask

   // Drive one weight to saturation, clamp it to zero, and keep it there.
   task automatic test_weight_limits();
      wait_quiet();
      csr_write(SPARE_ADDR, $urandom());
      csr_check_percent();
      csr_write(PCT_ADDR, '1);
      csr_check_percent();
      send_item(awsp_pkg::OP_SELECT, '0, 1'b0);
      repeat (13) send_item(awsp_pkg::OP_GRADE, $urandom(), 1'b0);
      send_item(awsp_pkg::OP_GRADE, $urandom(), 1'b1);
      send_item(awsp_pkg::OP_GRADE, $urandom(), 1'b0);
      wait_quiet();
      csr_write(PCT_ADDR, awsp_pkg::CSR_DATA_BITS'(awsp_pkg::PERCENT_BASE));
      send_item(awsp_pkg::OP_SELECT, '0, 1'b1);
      send_item(awsp_pkg::OP_GRADE, '1, 1'b1);
   endtask

   // Phases of select-then-grade sequences under a range of percent settings.
   task automatic test_random_traffic();
      logic [awsp_pkg::PCT_BITS-1:0]      pct;
      logic [awsp_pkg::CSR_DATA_BITS-1:0] wdata;
      logic [awsp_pkg::RAND_BITS-1:0]     rv;
      int unsigned                        sent;
      for (int phase = 0; phase < 8; phase++) begin
         wait_quiet();
         case (phase)
            0: pct = '0;
            1: pct = '1;
            2: pct = awsp_pkg::PCT_BITS'(awsp_pkg::PERCENT_BASE);
            3: pct = awsp_pkg::RESET_PCT;
            4: pct = awsp_pkg::PCT_BITS'(1);
            default: pct = awsp_pkg::PCT_BITS'($urandom_range(0, (1 << awsp_pkg::PCT_BITS) - 1));
         endcase
         wdata = $urandom();
         wdata[awsp_pkg::PCT_BITS-1:0] = pct;
         csr_write(PCT_ADDR, wdata);
         csr_check_percent();
         quiet_mode = (phase == 3);
         sent = 0;
         while (sent < 29) begin
            case ($urandom_range(0, 9))
               0:       rv = '0;
               1:       rv = awsp_pkg::RAND_BITS'($urandom_range(0, 999));
               2:       rv = '1;
               default: rv = $urandom();
            endcase
            send_item(awsp_pkg::OP_SELECT, rv, 1'($urandom_range(0, 1)));
            sent++;
            repeat ($urandom_range(0, 3)) begin
               send_item(awsp_pkg::OP_GRADE, $urandom(), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = awsp_pkg::OP_SELECT;
      req_bus.random_value   = '0;
      req_bus.answer_correct = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      error_count            = 0;
      checked_count          = 0;
      select_count           = 0;
      grade_count            = 0;
      setting_count          = 0;
      rsp_hold               = 0;
      quiet_mode             = 1'b0;
      for (int e = 0; e < awsp_pkg::ENTRIES; e++) weight_mirror[e] = awsp_pkg::START_WEIGHT;
      total_mirror = longint'(awsp_pkg::START_WEIGHT) * awsp_pkg::ENTRIES;
      last_a       = '0;
      last_b       = '0;
      last_c       = '0;
      pct_mirror   = awsp_pkg::RESET_PCT;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_grade_before_select();
      test_select_extremes();
      test_weight_limits();
      test_random_traffic();

      wait_quiet();
      repeat (40) @(posedge clock);
      if (pending_picks.size() != 0) begin
         note_error($sformatf("%0d results never arrived", pending_picks.size()));
      end
      $display("covered %0d selects and %0d grades under %0d percent settings",
               select_count, grade_count, setting_count);
      $display("%0d results checked against the table mirror", checked_count);
      if (error_count == 0) begin
         $display("adaptive_weighted_scenario_picker_tb: done, clean");
      end else begin
         $display("%0d errors", error_count);
         $display("adaptive_weighted_scenario_picker_tb: done, errors");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #40_000_000;
      $display("timeout with %0d results pending", pending_picks.size());
      $display("adaptive_weighted_scenario_picker_tb: done, errors");
      $finish;
   end

endmodule
